[src/servo_esc_pulse_mapper_defines.svh]
// Assertion macros for the servo and ESC pulse mapper.
// Needs a clock clk_i and an active-low reset rst_ni wherever it is used.
`ifndef SERVO_ESC_PULSE_MAPPER_DEFINES_SVH
`define SERVO_ESC_PULSE_MAPPER_DEFINES_SVH
`ifndef SYNTHESIS
`define SPM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SPM_ASSERT_IMPL(lbl, ante, cons)
`define SPM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[src/spm_pkg.sv]
// Types and constants shared by the pulse mapper modules.
// No dependencies.
package spm_pkg;

  localparam int unsigned NsW       = 26;
  localparam int unsigned QuoW      = 26;
  localparam int unsigned SpanW     = 15;
  localparam int unsigned NumW      = 41;
  localparam int unsigned DivSteps  = QuoW;
  localparam int unsigned LaneStages = DivSteps + 4;
  localparam int unsigned NumStages  = LaneStages + 1;
  localparam logic [9:0]  NsPerUs   = 10'd1000;

  typedef enum logic [2:0] {
    RegSteerLim   = 3'd0,
    RegThrotLim   = 3'd1,
    RegLeftIsMax  = 3'd2,
    RegSteerLeft  = 3'd3,
    RegSteerRight = 3'd4,
    RegSpeedFull  = 3'd5,
    RegTimeout    = 3'd6,
    RegPeriod     = 3'd7
  } spm_reg_e;

  typedef struct packed {
    logic               cmd_present;
    logic [15:0]        age_ms;
    logic signed [15:0] steering_mrad;
    logic signed [15:0] speed_mmps;
  } spm_in_t;

  typedef struct packed {
    logic [31:0] steering_duty_ns;
    logic [31:0] throttle_duty_ns;
    logic        stale;
  } spm_out_t;

  typedef struct packed {
    logic             stale;
    logic             neg;
    logic [15:0]      absdiff;
    logic [SpanW-1:0] mag;
    logic [SpanW-1:0] span;
    logic [15:0]      neu;
    logic [15:0]      mn;
    logic [15:0]      mx;
  } spm_lane_in_t;

  typedef struct packed {
    logic             stale;
    logic             neg;
    logic             zspan;
    logic [SpanW-1:0] span;
    logic [NsW-1:0]   neu_ns;
    logic [NsW-1:0]   mn_ns;
    logic [NsW-1:0]   mx_ns;
  } spm_meta_t;

  typedef struct packed {
    spm_meta_t        meta;
    logic [SpanW-1:0] rem;
    logic [QuoW-1:0]  num;
    logic [QuoW-1:0]  quo;
  } spm_div_t;

endpackage

[src/spm_div_stage.sv]
// One restoring division step: one quotient bit per stage.
// Depends on spm_pkg.
module spm_div_stage (
  input  logic              clk_i,
  input  logic              en_i,
  input  spm_pkg::spm_div_t div_i,
  output spm_pkg::spm_div_t div_o
);
  import spm_pkg::*;

  logic [SpanW:0]   r2;
  logic [SpanW:0]   diff;
  logic             ge;
  spm_div_t         div_d;
  spm_div_t         div_q;

  always_comb begin
    r2   = {div_i.rem, div_i.num[QuoW-1]};
    diff = r2 - {1'b0, div_i.meta.span};
    ge   = (r2 >= {1'b0, div_i.meta.span});
    div_d      = div_i;
    div_d.rem  = ge ? diff[SpanW-1:0] : r2[SpanW-1:0];
    div_d.num  = {div_i.num[QuoW-2:0], 1'b0};
    div_d.quo  = {div_i.quo[QuoW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;
endmodule

[src/spm_lane.sv]
// Datapath of one channel: scale, multiply, divide by span, round, clamp, bound.
// Depends on spm_pkg and spm_div_stage.
module spm_lane (
  input  logic                             clk_i,
  input  logic [spm_pkg::LaneStages-1:0]   en_i,
  input  spm_pkg::spm_lane_in_t            lane_i,
  input  logic [31:0]                      period_i,
  output logic [31:0]                      duty_o,
  output logic                             stale_o
);
  import spm_pkg::*;

  spm_meta_t        m1_d, m1_q;
  logic [NsW-1:0]   dns_d, dns_q;
  logic [SpanW-1:0] mag_q;
  logic [NumW-1:0]  n;
  spm_div_t         div2_d, div2_q;
  spm_div_t         div_w [DivSteps+1];
  spm_div_t         dq;
  logic [SpanW:0]   rem2;
  logic             up;
  logic [QuoW:0]    q;
  logic signed [27:0] neu_s;
  logic signed [27:0] v_d, v_q;
  logic               st_q;
  logic [NsW-1:0]     mn_q, mx_q;
  logic signed [27:0] c;
  logic [31:0]        duty_d, duty_q;
  logic               st_out_q;

  always_comb begin
    m1_d.stale  = lane_i.stale;
    m1_d.neg    = lane_i.neg;
    m1_d.zspan  = (lane_i.span == '0);
    m1_d.span   = lane_i.span;
    m1_d.neu_ns = NsW'(lane_i.neu) * NsW'(NsPerUs);
    m1_d.mn_ns  = NsW'(lane_i.mn) * NsW'(NsPerUs);
    m1_d.mx_ns  = NsW'(lane_i.mx) * NsW'(NsPerUs);
    dns_d       = NsW'(lane_i.absdiff) * NsW'(NsPerUs);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      m1_q  <= m1_d;
      dns_q <= dns_d;
      mag_q <= m1_d.zspan ? '0 : lane_i.mag;
    end
  end

  always_comb begin
    n           = NumW'(dns_q) * NumW'(mag_q);
    div2_d.meta = m1_q;
    div2_d.rem  = n[NumW-1:QuoW];
    div2_d.num  = n[QuoW-1:0];
    div2_d.quo  = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      div2_q <= div2_d;
    end
  end

  assign div_w[0] = div2_q;

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    spm_div_stage u_step (
      .clk_i (clk_i),
      .en_i  (en_i[2+i]),
      .div_i (div_w[i]),
      .div_o (div_w[i+1])
    );
  end

  always_comb begin
    dq    = div_w[DivSteps];
    rem2  = {dq.rem, 1'b0};
    up    = dq.meta.neg ? (rem2 > {1'b0, dq.meta.span}) : (rem2 >= {1'b0, dq.meta.span});
    q     = dq.meta.zspan ? '0 : ({1'b0, dq.quo} + (QuoW+1)'(up));
    neu_s = signed'({2'b00, dq.meta.neu_ns});
    if (dq.meta.stale) begin
      v_d = neu_s;
    end else if (dq.meta.neg) begin
      v_d = neu_s - signed'({1'b0, q});
    end else begin
      v_d = neu_s + signed'({1'b0, q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[LaneStages-2]) begin
      v_q  <= v_d;
      st_q <= dq.meta.stale;
      mn_q <= dq.meta.mn_ns;
      mx_q <= dq.meta.mx_ns;
    end
  end

  always_comb begin
    c = v_q;
    if (!st_q) begin
      if (v_q < signed'({2'b00, mn_q})) begin
        c = signed'({2'b00, mn_q});
      end else if (v_q > signed'({2'b00, mx_q})) begin
        c = signed'({2'b00, mx_q});
      end
    end
    if (c <= 28'sd0) begin
      duty_d = '0;
    end else if (32'(c[26:0]) >= period_i) begin
      duty_d = period_i;
    end else begin
      duty_d = 32'(c[26:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[LaneStages-1]) begin
      duty_q   <= duty_d;
      st_out_q <= st_q;
    end
  end

  assign duty_o  = duty_q;
  assign stale_o = st_out_q;
endmodule

[src/servo_esc_pulse_mapper.sv]
// Servo and ESC pulse mapper: command in, two PWM duty times in ns out.
// One request is accepted per cycle unless back-pressure from out_ready_i stalls the pipeline.
// The depth is set by the 26-step restoring divider by the configured span.
// Reset clears all valid bits and loads the configuration reset values.
// Depends on spm_pkg, spm_lane and servo_esc_pulse_mapper_defines.svh.
`include "servo_esc_pulse_mapper_defines.svh"
module servo_esc_pulse_mapper (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spm_pkg::spm_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spm_pkg::spm_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [5:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);
  import spm_pkg::*;

  logic [47:0]      steer_lim_q, throt_lim_q;
  logic             left_max_q;
  logic [14:0]      left_lim_q, right_lim_q, speed_fs_q;
  logic [15:0]      timeout_q;
  logic [31:0]      period_q;
  spm_reg_e         waddr;
  logic             wr;

  assign pready = 1'b1;
  assign waddr  = spm_reg_e'(paddr[5:3]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steer_lim_q <= '0;
      throt_lim_q <= '0;
      left_max_q  <= 1'b0;
      left_lim_q  <= 15'd1;
      right_lim_q <= 15'd1;
      speed_fs_q  <= 15'd1;
      timeout_q   <= 16'd1;
      period_q    <= 32'd20000000;
    end else if (wr) begin
      case (waddr)
        RegSteerLim:   steer_lim_q <= pwdata[47:0];
        RegThrotLim:   throt_lim_q <= pwdata[47:0];
        RegLeftIsMax:  left_max_q  <= pwdata[0];
        RegSteerLeft:  left_lim_q  <= pwdata[14:0];
        RegSteerRight: right_lim_q <= pwdata[14:0];
        RegSpeedFull:  speed_fs_q  <= pwdata[14:0];
        RegTimeout:    timeout_q   <= pwdata[15:0];
        RegPeriod:     period_q    <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (waddr)
      RegSteerLim:   prdata = 64'(steer_lim_q);
      RegThrotLim:   prdata = 64'(throt_lim_q);
      RegLeftIsMax:  prdata = 64'(left_max_q);
      RegSteerLeft:  prdata = 64'(left_lim_q);
      RegSteerRight: prdata = 64'(right_lim_q);
      RegSpeedFull:  prdata = 64'(speed_fs_q);
      RegTimeout:    prdata = 64'(timeout_q);
      RegPeriod:     prdata = 64'(period_q);
      default:       prdata = '0;
    endcase
  end

  logic [NumStages-1:0] vld_q;
  logic [NumStages:0]   rdy;

  assign rdy[NumStages] = out_ready_i;
  for (genvar k = 0; k < NumStages; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NumStages-1];

  logic               stale;
  logic               steer_pos, speed_pos;
  logic [15:0]        smin, sneu, smax, tmin, tneu, tmax, send, tend;
  logic [16:0]        smag_raw, tmag_raw;
  logic [14:0]        sspan, tspan;
  logic signed [16:0] sdiff, tdiff;
  spm_lane_in_t       s_d, t_d, s_q, t_q;

  always_comb begin
    smin = steer_lim_q[47:32];
    sneu = steer_lim_q[31:16];
    smax = steer_lim_q[15:0];
    tmin = throt_lim_q[47:32];
    tneu = throt_lim_q[31:16];
    tmax = throt_lim_q[15:0];
    stale     = !in_data_i.cmd_present || (in_data_i.age_ms >= timeout_q);
    steer_pos = !in_data_i.steering_mrad[15];
    speed_pos = !in_data_i.speed_mmps[15];
    smag_raw  = steer_pos ? 17'(unsigned'(in_data_i.steering_mrad))
                          : 17'd0 - {1'b1, in_data_i.steering_mrad};
    tmag_raw  = speed_pos ? 17'(unsigned'(in_data_i.speed_mmps))
                          : 17'd0 - {1'b1, in_data_i.speed_mmps};
    sspan = steer_pos ? left_lim_q : right_lim_q;
    tspan = speed_fs_q;
    send  = (steer_pos == left_max_q) ? smax : smin;
    tend  = speed_pos ? tmax : tmin;
    sdiff = signed'({1'b0, send}) - signed'({1'b0, sneu});
    tdiff = signed'({1'b0, tend}) - signed'({1'b0, tneu});

    s_d.stale   = stale;
    s_d.neg     = sdiff[16];
    s_d.absdiff = sdiff[16] ? 16'(-sdiff) : sdiff[15:0];
    s_d.mag     = (smag_raw > {2'b00, sspan}) ? sspan : smag_raw[14:0];
    s_d.span    = sspan;
    s_d.neu     = sneu;
    s_d.mn      = smin;
    s_d.mx      = smax;

    t_d.stale   = stale;
    t_d.neg     = tdiff[16];
    t_d.absdiff = tdiff[16] ? 16'(-tdiff) : tdiff[15:0];
    t_d.mag     = (tmag_raw > {2'b00, tspan}) ? tspan : tmag_raw[14:0];
    t_d.span    = tspan;
    t_d.neu     = tneu;
    t_d.mn      = tmin;
    t_d.mx      = tmax;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s_q <= s_d;
      t_q <= t_d;
    end
  end

  logic unused_stale;

  spm_lane u_steer (
    .clk_i    (clk_i),
    .en_i     (rdy[NumStages-1:1]),
    .lane_i   (s_q),
    .period_i (period_q),
    .duty_o   (out_data_o.steering_duty_ns),
    .stale_o  (out_data_o.stale)
  );

  spm_lane u_throt (
    .clk_i    (clk_i),
    .en_i     (rdy[NumStages-1:1]),
    .lane_i   (t_q),
    .period_i (period_q),
    .duty_o   (out_data_o.throttle_duty_ns),
    .stale_o  (unused_stale)
  );

  `SPM_ASSERT_IMPL(a_steer_bound, out_valid_o, out_data_o.steering_duty_ns <= period_q)
  `SPM_ASSERT_IMPL(a_throt_bound, out_valid_o, out_data_o.throttle_duty_ns <= period_q)
  `SPM_ASSERT_IMPL(a_no_stall, out_ready_i, in_ready_o)
  `SPM_ASSERT_NEXT(a_first_stage, in_valid_i && in_ready_o, vld_q[0])
endmodule
